/* rtl/core/ptwr_pkg.sv */
package ptwr_pkg;

  // Function codes of an input item.
  localparam logic [1:0] FN_RECEIVE = 2'd0;
  localparam logic [1:0] FN_ADD     = 2'd1;
  localparam logic [1:0] FN_MARK    = 2'd2;
  localparam logic [1:0] FN_LIST    = 2'd3;

  // Result status codes.
  localparam logic [3:0] ST_ACCEPTED  = 4'd0;
  localparam logic [3:0] ST_REPLAY    = 4'd1;
  localparam logic [3:0] ST_UNKNOWN   = 4'd2;
  localparam logic [3:0] ST_ADDED     = 4'd3;
  localparam logic [3:0] ST_FULL      = 4'd4;
  localparam logic [3:0] ST_MARKED    = 4'd5;
  localparam logic [3:0] ST_BAD_INDEX = 4'd6;
  localparam logic [3:0] ST_LOST      = 4'd7;
  localparam logic [3:0] ST_NONE_LOST = 4'd8;

  // A lost-check lists at most this many entries.
  localparam int MAX_RESULTS = 8;
  localparam int HIT_W       = 3;

  localparam logic [7:0] TIMEOUT_RESET = 8'd50;
  localparam logic [7:0] IDLE_MAX      = 8'hFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [31:0] packet_sequence;
    logic [2:0]  target_entry;
  } in_item_t;

  typedef struct packed {
    logic [3:0] status;
    logic [2:0] entry_index;
    logic [3:0] removed_count;
    logic [3:0] peer_count;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [31:0] seq;
    logic [7:0]  idle;
  } entry_t;

  typedef struct packed {
    logic shift_en;   // move one place toward the head
    logic take_head;  // on a shift, take the updated head instead of the neighbor
    logic load_en;    // write a new entry
    logic mark_en;    // set the sequence number to one
  } cell_ctrl_t;

endpackage

/* rtl/core/peer_table_with_replay_check.sv */
// Peer table with idle ageing and a replay check.
//
// Input items arrive on in_valid/in_data and are taken when in_stall is low;
// the block raises in_stall while it works on an item. Results leave on
// out_valid/out_data and are held unchanged while out_stall is high. The
// timeout limit is written through cfg_valid/cfg_ready/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
//
// Order: an add or mark-sent item is registered as a result in S_DONE and
// then in the output register. A receive item rotates the occupied entries
// once past the head compare unit, one entry a cycle, then goes to S_DONE.
// A lost-check walks a snapshot of the entries one bit a cycle, waiting on a
// lost entry while the output stalls, and goes to S_DONE when nothing is lost.
// The next item is accepted in the cycle after the last result is registered.
//
// Reset empties the table and sets the timeout limit to 50. A stalled
// receiver holds the block in a step that gives a result; no item is lost.
module peer_table_with_replay_check #(
  parameter int MAX_ENTRIES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ptwr_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ptwr_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int HIT_W_L = ptwr_pkg::HIT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LIST = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [CW-1:0]           total_r, total_nxt;
  logic [7:0]              limit_r;
  logic                    out_valid_r, out_valid_nxt;
  ptwr_pkg::out_item_t     out_data_r, out_data_nxt;
  ptwr_pkg::in_item_t      req_r, req_nxt;
  ptwr_pkg::out_item_t     res_r, res_nxt;
  logic [CW-1:0]           steps_r, steps_nxt;
  logic [CW-1:0]           kept_r, kept_nxt;
  logic                    matched_r, matched_nxt;
  logic [MAX_ENTRIES-1:0]  mask_r, mask_nxt;
  logic [IW-1:0]           pos_r, pos_nxt;
  logic [HIT_W_L-1:0]      hits_r, hits_nxt;

  ptwr_pkg::entry_t        cell_q [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  seq_one;
  logic [MAX_ENTRIES-1:0]  lost_vec;
  ptwr_pkg::entry_t        head;
  ptwr_pkg::entry_t        head_upd;
  ptwr_pkg::entry_t        load_entry;
  logic                    in_acc;
  logic                    out_free;
  logic                    shift_all;
  logic                    keep;
  logic                    head_match;
  logic [7:0]              idle_inc;
  logic                    too_old;
  logic                    lost_last;
  logic                    is_full;
  logic                    mark_ok;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign head       = cell_q[0];
  assign head_match = (head.addr_high == req_r.address_high) &&
                      (head.addr_low == req_r.address_low);
  assign idle_inc   = (head.idle == ptwr_pkg::IDLE_MAX) ? ptwr_pkg::IDLE_MAX
                                                         : head.idle + 8'd1;
  assign too_old    = (idle_inc > limit_r);
  assign lost_last  = ((mask_r >> 1) == '0) ||
                      (hits_r == HIT_W_L'(ptwr_pkg::MAX_RESULTS - 1));
  assign is_full    = (total_r == CW'(MAX_ENTRIES));
  assign mark_ok    = (8'(in_data.target_entry) < 8'(total_r));

  assign load_entry = '{addr_high: in_data.address_high,
                        addr_low:  in_data.address_low,
                        seq:       32'd0,
                        idle:      8'd0};

  // The row of entry cells. Entry 0 is always the head of the ring; during a
  // receive scan the whole row moves one place each cycle and the processed
  // head re-enters at the tail of the occupied part, or is dropped when it
  // has timed out. A full pass restores the original order.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    ptwr_pkg::cell_ctrl_t ctrl;
    ptwr_pkg::entry_t     right;

    assign ctrl.shift_en  = shift_all;
    assign ctrl.take_head = keep && (total_r == CW'(i + 1));
    assign ctrl.load_en   = in_acc && (in_data.func == ptwr_pkg::FN_ADD) &&
                            (total_r == CW'(i));
    assign ctrl.mark_en   = in_acc && (in_data.func == ptwr_pkg::FN_MARK) &&
                            (8'(in_data.target_entry) == 8'(i)) &&
                            (CW'(i) < total_r);

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign right = head_upd;
    end else begin : g_mid
      assign right = cell_q[i + 1];
    end

    assign lost_vec[i] = seq_one[i] && (CW'(i) < total_r);

    ptwr_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .right_in (right),
      .head_in  (head_upd),
      .load_in  (load_entry),
      .entry_o  (cell_q[i]),
      .seq_one  (seq_one[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    steps_nxt     = steps_r;
    kept_nxt      = kept_r;
    matched_nxt   = matched_r;
    mask_nxt      = mask_r;
    pos_nxt       = pos_r;
    hits_nxt      = hits_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    shift_all     = 1'b0;
    keep          = 1'b0;
    head_upd      = head;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_nxt = '{status: ptwr_pkg::ST_UNKNOWN, entry_index: 3'd0,
                      removed_count: 4'd0, peer_count: 4'd0, last: 1'b1};
          unique case (in_data.func)
            ptwr_pkg::FN_RECEIVE: begin
              req_nxt     = in_data;
              steps_nxt   = total_r;
              kept_nxt    = '0;
              matched_nxt = 1'b0;
              state_nxt   = S_SCAN;
            end
            ptwr_pkg::FN_ADD: begin
              if (is_full) begin
                res_nxt.status = ptwr_pkg::ST_FULL;
              end else begin
                res_nxt.status      = ptwr_pkg::ST_ADDED;
                res_nxt.entry_index = 3'(total_r);
                total_nxt           = total_r + 1'b1;
              end
              state_nxt = S_DONE;
            end
            ptwr_pkg::FN_MARK: begin
              res_nxt.status      = mark_ok ? ptwr_pkg::ST_MARKED
                                            : ptwr_pkg::ST_BAD_INDEX;
              res_nxt.entry_index = in_data.target_entry;
              state_nxt           = S_DONE;
            end
            ptwr_pkg::FN_LIST: begin
              mask_nxt  = lost_vec;
              pos_nxt   = '0;
              hits_nxt  = '0;
              state_nxt = S_LIST;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (steps_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          shift_all = 1'b1;
          steps_nxt = steps_r - 1'b1;
          if (matched_r) begin
            keep = 1'b1;
          end else if (head_match) begin
            keep          = 1'b1;
            head_upd.idle = 8'd0;
            if (req_r.packet_sequence > head.seq) begin
              head_upd.seq   = req_r.packet_sequence;
              res_nxt.status = ptwr_pkg::ST_ACCEPTED;
            end else begin
              res_nxt.status = ptwr_pkg::ST_REPLAY;
            end
            res_nxt.entry_index = 3'(kept_r);
            matched_nxt         = 1'b1;
          end else if (too_old) begin
            total_nxt             = total_r - 1'b1;
            res_nxt.removed_count = res_r.removed_count + 4'd1;
          end else begin
            keep          = 1'b1;
            head_upd.idle = idle_inc;
            kept_nxt      = kept_r + 1'b1;
          end
        end
      end

      S_LIST: begin
        if (mask_r == '0) begin
          // Nothing was listed, so the single result says so.
          res_nxt   = '{status: ptwr_pkg::ST_NONE_LOST, entry_index: 3'd0,
                        removed_count: 4'd0, peer_count: 4'd0, last: 1'b1};
          state_nxt = S_DONE;
        end else if (mask_r[0]) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: ptwr_pkg::ST_LOST, entry_index: 3'(pos_r),
                              removed_count: 4'd0, peer_count: 4'(total_r),
                              last: lost_last};
            hits_nxt      = hits_r + 1'b1;
            mask_nxt      = mask_r >> 1;
            pos_nxt       = pos_r + 1'b1;
            if (lost_last) begin
              state_nxt = S_IDLE;
            end
          end
        end else begin
          mask_nxt = mask_r >> 1;
          pos_nxt  = pos_r + 1'b1;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt            = res_r;
          out_data_nxt.peer_count = 4'(total_r);
          out_data_nxt.last       = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      limit_r     <= ptwr_pkg::TIMEOUT_RESET;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    steps_r    <= steps_nxt;
    kept_r     <= kept_nxt;
    matched_r  <= matched_nxt;
    mask_r     <= mask_nxt;
    pos_r      <= pos_nxt;
    hits_r     <= hits_nxt;
  end

endmodule

/* rtl/core/ptwr_cell.sv */
// One table entry. On a shift it takes its right neighbor, or the updated
// head entry when it is the tail of the occupied ring.
module ptwr_cell (
  input  logic                clk,
  input  ptwr_pkg::cell_ctrl_t ctrl,
  input  ptwr_pkg::entry_t    right_in,
  input  ptwr_pkg::entry_t    head_in,
  input  ptwr_pkg::entry_t    load_in,
  output ptwr_pkg::entry_t    entry_o,
  output logic                seq_one
);

  ptwr_pkg::entry_t entry_r;
  ptwr_pkg::entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctrl.shift_en) begin
      entry_nxt = ctrl.take_head ? head_in : right_in;
    end else if (ctrl.load_en) begin
      entry_nxt = load_in;
    end else if (ctrl.mark_en) begin
      entry_nxt.seq = 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign seq_one = (entry_r.seq == 32'd1);

endmodule
